@@ rtl/core/keypad_scan_debouncer_assert.svh @@
// Assertion macros shared by the keypad scan debouncer RTL.
`ifndef KEYPAD_SCAN_DEBOUNCER_ASSERT_SVH
`define KEYPAD_SCAN_DEBOUNCER_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, disabled during reset.
`define KPSD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, disabled during reset.
`define KPSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/kpsd_pkg.sv @@
// Package: constants, key table and shared types of the keypad scan debouncer.
`default_nettype none
package kpsd_pkg;

  localparam int unsigned CountWidth    = 16;
  localparam int unsigned IntervalWidth = 16;
  localparam int unsigned CharWidth     = 8;
  localparam int unsigned NibWidth      = 4;

  localparam logic [IntervalWidth-1:0] IntervalReset = 16'd100;
  localparam logic [CharWidth-1:0]     KeyNone       = 8'h0f;

  // ASCII characters indexed by {row, column}
  localparam logic [CharWidth-1:0] KeyChars [16] = '{
    8'h31, 8'h32, 8'h33, 8'h61,   // 1 2 3 a
    8'h34, 8'h35, 8'h36, 8'h62,   // 4 5 6 b
    8'h37, 8'h38, 8'h39, 8'h63,   // 7 8 9 c
    8'h2a, 8'h30, 8'h23, 8'h64    // * 0 # d
  };

  typedef enum logic [3:0] {
    StIdle    = 4'b0001,
    StConfirm = 4'b0010,
    StRelease = 4'b0100,
    StReport  = 4'b1000
  } db_stage_e;

  // One scan event toward the debouncer
  typedef struct packed {
    logic                 fire;
    logic [CharWidth-1:0] key;
  } scan_t;

endpackage
`default_nettype wire

@@ rtl/core/kpsd_in_if.sv @@
// Interface: input channel carrying the four column readback nibbles.
`default_nettype none
interface kpsd_in_if
  import kpsd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [NibWidth-1:0] cols_row0;
  logic [NibWidth-1:0] cols_row1;
  logic [NibWidth-1:0] cols_row2;
  logic [NibWidth-1:0] cols_row3;

  modport source (output valid, output cols_row0, output cols_row1,
                  output cols_row2, output cols_row3, input ready);
  modport sink   (input valid, input cols_row0, input cols_row1,
                  input cols_row2, input cols_row3, output ready);
endinterface
`default_nettype wire

@@ rtl/core/kpsd_out_if.sv @@
// Interface: output channel carrying the debounced key character.
`default_nettype none
interface kpsd_out_if
  import kpsd_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] key_char;

  modport source (output valid, output key_char, input ready);
  modport sink   (input valid, input key_char, output ready);
endinterface
`default_nettype wire

@@ rtl/core/keypad_scan_debouncer.sv @@
// Top level of the keypad scan debouncer.
// Each accepted word is one timer tick carrying the four active-low column
// nibbles of a 4x4 keypad. A 16-bit prescaler reloaded from scan_interval
// (reset 100, written via scan_interval_we_i) picks every Nth tick as a scan;
// an interval of 0 gives a period of 65536 ticks, and a new value applies at
// the next reload. On a scan the first row with exactly one low column gives
// the key, which runs through detect, confirm, wait-for-release and report;
// the report scan emits the key's ASCII character. A word is taken every
// cycle; a result appears in the output register in the cycle after the
// tick that causes it, and ingest stalls only while that register holds a
// result the sink has not yet taken.
`default_nettype none
module keypad_scan_debouncer
  import kpsd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     scan_interval_we_i,
  input  wire logic [IntervalWidth-1:0] scan_interval_i,
  kpsd_in_if.sink                       in_if,
  kpsd_out_if.source                    out_if
);

  logic                 slot_free;
  logic                 accept;
  logic                 cnt_fire;
  logic [CharWidth-1:0] key;
  scan_t                scan;

  assign in_if.ready = slot_free;
  assign accept      = in_if.valid && slot_free;

  kpsd_prescaler u_prescaler (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (scan_interval_we_i),
    .cfg_data_i (scan_interval_i),
    .tick_i     (accept),
    .fire_o     (cnt_fire)
  );

  kpsd_decode u_decode (
    .cols_row0_i (in_if.cols_row0),
    .cols_row1_i (in_if.cols_row1),
    .cols_row2_i (in_if.cols_row2),
    .cols_row3_i (in_if.cols_row3),
    .key_o       (key)
  );

  assign scan.fire = accept && cnt_fire;
  assign scan.key  = key;

  kpsd_debounce u_debounce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scan_i      (scan),
    .slot_free_o (slot_free),
    .out_if      (out_if)
  );

endmodule
`default_nettype wire

@@ rtl/core/kpsd_prescaler.sv @@
// Tick prescaler: scan interval register and down counter that times scans.
`default_nettype none
module kpsd_prescaler
  import kpsd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [IntervalWidth-1:0] cfg_data_i,
  input  wire logic                     tick_i,
  output logic                          fire_o
);

  logic [IntervalWidth-1:0] interval_q;
  logic [CountWidth-1:0]    cnt_q, cnt_d, cnt_dec;

  assign cnt_dec = cnt_q - 1'b1;
  assign fire_o  = (cnt_dec == '0);

  // Zero interval reloads zero, so the next decrement wraps to a full period
  always_comb begin
    cnt_d = cnt_q;
    if (tick_i) begin
      cnt_d = fire_o ? CountWidth'(interval_q) : cnt_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IntervalReset;
      cnt_q      <= CountWidth'(IntervalReset);
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_data_i;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/kpsd_decode.sv @@
// Key decoder: first row with exactly one low column selects the character.
`default_nettype none
module kpsd_decode
  import kpsd_pkg::*;
(
  input  wire logic [NibWidth-1:0] cols_row0_i,
  input  wire logic [NibWidth-1:0] cols_row1_i,
  input  wire logic [NibWidth-1:0] cols_row2_i,
  input  wire logic [NibWidth-1:0] cols_row3_i,
  output logic [CharWidth-1:0]     key_o
);

  typedef struct packed {
    logic       hit;
    logic [1:0] col;
  } col_hit_t;

  function automatic col_hit_t single_low(input logic [NibWidth-1:0] nib);
    col_hit_t res;
    res = '{hit: 1'b1, col: 2'd0};
    case (nib)
      4'he:    res.col = 2'd0;
      4'hd:    res.col = 2'd1;
      4'hb:    res.col = 2'd2;
      4'h7:    res.col = 2'd3;
      default: res.hit = 1'b0;
    endcase
    return res;
  endfunction

  col_hit_t h0, h1, h2, h3;

  assign h0 = single_low(cols_row0_i);
  assign h1 = single_low(cols_row1_i);
  assign h2 = single_low(cols_row2_i);
  assign h3 = single_low(cols_row3_i);

  always_comb begin
    if (h0.hit) begin
      key_o = KeyChars[{2'd0, h0.col}];
    end else if (h1.hit) begin
      key_o = KeyChars[{2'd1, h1.col}];
    end else if (h2.hit) begin
      key_o = KeyChars[{2'd2, h2.col}];
    end else if (h3.hit) begin
      key_o = KeyChars[{2'd3, h3.col}];
    end else begin
      key_o = KeyNone;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/kpsd_debounce.sv @@
// Debounce state machine and result register with output handshake.
`default_nettype none
module kpsd_debounce
  import kpsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire scan_t       scan_i,
  output logic             slot_free_o,
  kpsd_out_if.source       out_if
);

`include "keypad_scan_debouncer_assert.svh"

  db_stage_e            stage_q, stage_d;
  logic [CharWidth-1:0] held_q, held_d;
  logic                 out_valid_q, out_valid_d;
  logic [CharWidth-1:0] out_key_q, out_key_d;
  logic                 load;

  // A new word may enter while the pending result is taken in the same cycle
  assign slot_free_o = !out_valid_q || out_if.ready;

  always_comb begin
    stage_d = stage_q;
    held_d  = held_q;
    load    = 1'b0;
    if (scan_i.fire) begin
      case (stage_q)
        StIdle: begin
          if (scan_i.key != KeyNone) begin
            held_d  = scan_i.key;
            stage_d = StConfirm;
          end
        end
        StConfirm: begin
          stage_d = (scan_i.key == held_q) ? StRelease : StIdle;
        end
        StRelease: begin
          if (scan_i.key == KeyNone) begin
            stage_d = StReport;
          end
        end
        StReport: begin
          load    = 1'b1;
          stage_d = StIdle;
        end
        default: stage_d = StIdle;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_if.ready;
    out_key_d   = out_key_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_key_d   = held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= StIdle;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      stage_q     <= stage_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_key_q <= out_key_d;
  end

  assign out_if.valid    = out_valid_q;
  assign out_if.key_char = out_key_q;

  `KPSD_ASSERT_NEXT(a_report_loads, scan_i.fire && stage_q == StReport, out_valid_q && out_key_q == $past(held_q), "report scan did not load held key")
  `KPSD_ASSERT_NEXT(a_stage_hold, !scan_i.fire, stage_q == $past(stage_q), "stage moved without a scan")
  `KPSD_ASSERT_IMPLY(a_held_real_key, stage_q == StConfirm || stage_q == StRelease, held_q != KeyNone, "held key is empty while confirming")

endmodule
`default_nettype wire
